@@ hdl/arma_css_loss_gradient_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ARMA loss and gradient engine
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ARMA_CSS_LOSS_GRADIENT_MACROS_SVH
`define ARMA_CSS_LOSS_GRADIENT_MACROS_SVH

// Same-cycle implication.
`define ACL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/acl_pkg.sv @@
// ---------------------------------------------------------------------------
// ARMA loss and gradient package
// Sizes, codes, shared structs and arithmetic helpers of the engine.
// ---------------------------------------------------------------------------
package acl_pkg;

  localparam int MAX_AR     = 4;
  localparam int MAX_MA     = 4;
  localparam int COEF_WIDTH = 16;
  localparam int COEF_FRAC  = COEF_WIDTH - 2;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int CFG_W      = 64;
  localparam int OUT_SLOT_W = 4;

  localparam int NUM_SLOTS  = MAX_AR + MAX_MA + 1;
  localparam int NUM_FILT   = NUM_SLOTS + 1;
  localparam int AR_BASE    = 1;
  localparam int MA_BASE    = 1 + MAX_AR;
  localparam int INT_FILT   = 1 + MAX_AR + MAX_MA;
  localparam int FILT_W     = $clog2(NUM_FILT);
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int ORD_W      = $clog2((MAX_AR > MAX_MA ? MAX_AR : MAX_MA) + 1);
  localparam int AR_IW      = (MAX_AR > 1) ? $clog2(MAX_AR) : 1;
  localparam int MA_IW      = (MAX_MA > 1) ? $clog2(MAX_MA) : 1;
  localparam int ONE_Q16    = 65536;

  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_AR_ORDER  = 3'd0,
    REG_MA_ORDER  = 3'd1,
    REG_USE_INT   = 3'd2,
    REG_INTERCEPT = 3'd3,
    REG_AR_COEFFS = 3'd4,
    REG_MA_COEFFS = 3'd5,
    REG_GRAD_EN   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_RES  = 2'd0,
    KIND_LOSS = 2'd1,
    KIND_GRAD = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_WARM, OP_INIT, OP_MUL, OP_MACC, OP_ROUND, OP_SQR,
    OP_LACC, OP_GMUL, OP_GACC, OP_COMMIT, OP_EMIT_RES, OP_EMIT_LOSS,
    OP_EMIT_GRAD, OP_CLEAR
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_MUL, ST_ACC, ST_ROUND, ST_SQR, ST_LACC, ST_GMUL,
    ST_GACC1, ST_GACC2, ST_NEXT, ST_INIT, ST_COMMIT, ST_ERES, ST_ELOSS,
    ST_EGRAD, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [ORD_W-1:0]         p;
    logic [ORD_W-1:0]         q;
    logic                     use_int;
    logic                     grad_en;
    logic signed [DATA_W-1:0] intercept;
    logic [CFG_W-1:0]         ar_coeffs;
    logic [CFG_W-1:0]         ma_coeffs;
  } cfg_t;

  typedef struct packed {
    dp_op_t            op;
    logic [FILT_W-1:0] filt;
    logic [CNT_W-1:0]  idx;
    logic              use_phi;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic last_in;
    logic out_free;
  } dp_status_t;

  // Saturating 64-bit addition.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // Coefficient k of a packed register; zero when it lies past the top bit.
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(
    input logic [CFG_W-1:0] r,
    input logic [CNT_W-1:0] k
  );
    if ((int'(k) + 1) * COEF_WIDTH > CFG_W) begin
      return '0;
    end
    return r[int'(k)*COEF_WIDTH +: COEF_WIDTH];
  endfunction

endpackage

@@ hdl/acl_cfg.sv @@
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the written registers and presents them with the orders clamped.
// ---------------------------------------------------------------------------
module acl_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output acl_pkg::cfg_t        cfg
);
  import acl_pkg::*;

  logic [2:0]         ar_order;
  logic [2:0]         ma_order;
  logic               use_intercept;
  logic [DATA_W-1:0]  intercept;
  logic [CFG_W-1:0]   ar_coeffs;
  logic [CFG_W-1:0]   ma_coeffs;
  logic               gradient_enable;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ar_order        <= '0;
      ma_order        <= '0;
      use_intercept   <= 1'b0;
      intercept       <= '0;
      ar_coeffs       <= '0;
      ma_coeffs       <= '0;
      gradient_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AR_ORDER:  ar_order        <= cfg_data[2:0];
        REG_MA_ORDER:  ma_order        <= cfg_data[2:0];
        REG_USE_INT:   use_intercept   <= cfg_data[0];
        REG_INTERCEPT: intercept       <= cfg_data[DATA_W-1:0];
        REG_AR_COEFFS: ar_coeffs       <= cfg_data;
        REG_MA_COEFFS: ma_coeffs       <= cfg_data;
        REG_GRAD_EN:   gradient_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Orders above the maximum are clamped.
  always_comb begin
    cfg.p         = (int'(ar_order) > MAX_AR) ? ORD_W'(MAX_AR) : ORD_W'(ar_order);
    cfg.q         = (int'(ma_order) > MAX_MA) ? ORD_W'(MAX_MA) : ORD_W'(ma_order);
    cfg.use_int   = use_intercept;
    cfg.grad_en   = gradient_enable;
    cfg.intercept = signed'(intercept);
    cfg.ar_coeffs = ar_coeffs;
    cfg.ma_coeffs = ma_coeffs;
  end

endmodule

@@ hdl/acl_ctrl.sv @@
// ---------------------------------------------------------------------------
// Sequencer
// Steps the shared multiply-accumulate datapath through each sample's filters
// and drives the result emission.
// ---------------------------------------------------------------------------
module acl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  acl_pkg::cfg_t        cfg,
  input  acl_pkg::dp_status_t  status,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output acl_pkg::dp_cmd_t     cmd
);
  import acl_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [FILT_W-1:0] f;
  logic [FILT_W-1:0] f_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              phi_ph;
  logic              phi_ph_next;

  logic [FILT_W:0]   f_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  nslots;
  logic              last_term;
  logic              f_inc_valid;
  logic              acc_f;
  logic [SLOT_W-1:0] slot_of_f;
  logic [FILT_W-1:0] ar_k;
  logic [FILT_W-1:0] ma_k;

  // Derived counts and filter decode.
  always_comb begin
    f_inc     = {1'b0, f} + (FILT_W+1)'(1);
    cnt_inc   = cnt + CNT_W'(1);
    nslots    = cfg.grad_en ? (CNT_W'(cfg.p) + CNT_W'(cfg.q) + CNT_W'(cfg.use_int)) : '0;
    last_term = phi_ph ? (cnt_inc == CNT_W'(cfg.p)) : (cnt_inc == CNT_W'(cfg.q));
    ar_k      = FILT_W'(int'(f) - AR_BASE);
    ma_k      = FILT_W'(int'(f) - MA_BASE);
    acc_f     = (int'(f) != INT_FILT) || cfg.use_int;
    if (int'(f) < MA_BASE) begin
      slot_of_f = SLOT_W'(ar_k);
    end else if (int'(f) < INT_FILT) begin
      slot_of_f = SLOT_W'(cfg.p) + SLOT_W'(ma_k);
    end else begin
      slot_of_f = SLOT_W'(cfg.p) + SLOT_W'(cfg.q);
    end
    if (int'(f_inc) < MA_BASE) begin
      f_inc_valid = (int'(f_inc) - AR_BASE) < int'(cfg.p);
    end else if (int'(f_inc) < INT_FILT) begin
      f_inc_valid = (int'(f_inc) - MA_BASE) < int'(cfg.q);
    end else begin
      f_inc_valid = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_START;
      ST_START: begin
        if (!status.active) begin
          state_next = ST_COMMIT;
        end else if (cfg.p != '0 || cfg.q != '0) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_ROUND;
        end
      end
      ST_MUL:    state_next = ST_ACC;
      ST_ACC: begin
        if (last_term && (!phi_ph || cfg.q == '0)) begin
          state_next = ST_ROUND;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_ROUND: begin
        if (f == '0) begin
          state_next = ST_SQR;
        end else if (acc_f) begin
          state_next = ST_GMUL;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_SQR:    state_next = ST_LACC;
      ST_LACC:   state_next = ST_NEXT;
      ST_GMUL:   state_next = ST_GACC1;
      ST_GACC1:  state_next = ST_GACC2;
      ST_GACC2:  state_next = ST_NEXT;
      ST_NEXT: begin
        if ((f == '0 && !cfg.grad_en) || int'(f_inc) == NUM_FILT) begin
          state_next = ST_COMMIT;
        end else if (f_inc_valid) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT:   state_next = (cfg.q != '0) ? ST_MUL : ST_ROUND;
      ST_COMMIT: state_next = ST_ERES;
      ST_ERES: begin
        if (status.out_free) state_next = status.last_in ? ST_ELOSS : ST_IDLE;
      end
      ST_ELOSS: begin
        if (status.out_free) state_next = (nslots == '0) ? ST_CLEAR : ST_EGRAD;
      end
      ST_EGRAD: begin
        if (status.out_free && cnt_inc == nslots) state_next = ST_CLEAR;
      end
      ST_CLEAR:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Counter updates.
  always_comb begin
    f_next      = f;
    cnt_next    = cnt;
    phi_ph_next = phi_ph;
    case (state)
      ST_IDLE: begin
        f_next   = '0;
        cnt_next = '0;
      end
      ST_START: begin
        cnt_next    = '0;
        phi_ph_next = (cfg.p != '0);
      end
      ST_ACC: begin
        if (last_term) begin
          if (phi_ph && cfg.q != '0) begin
            phi_ph_next = 1'b0;
            cnt_next    = '0;
          end
        end else begin
          cnt_next = cnt_inc;
        end
      end
      ST_NEXT:  f_next = f_inc[FILT_W-1:0];
      ST_INIT: begin
        cnt_next    = '0;
        phi_ph_next = 1'b0;
      end
      ST_ELOSS: cnt_next = '0;
      ST_EGRAD: if (status.out_free) cnt_next = cnt_inc;
      default: ;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    s_tready    = 1'b0;
    cmd.op      = OP_NOP;
    cmd.filt    = f;
    cmd.idx     = cnt;
    cmd.use_phi = phi_ph;
    cmd.slot    = slot_of_f;
    cmd.last    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = OP_LOAD;
      end
      ST_START:  cmd.op = status.active ? OP_INIT : OP_WARM;
      ST_MUL:    cmd.op = OP_MUL;
      ST_ACC:    cmd.op = OP_MACC;
      ST_ROUND:  cmd.op = OP_ROUND;
      ST_SQR:    cmd.op = OP_SQR;
      ST_LACC:   cmd.op = OP_LACC;
      ST_GMUL:   cmd.op = OP_GMUL;
      ST_GACC1:  cmd.op = OP_GACC;
      ST_GACC2:  cmd.op = OP_GACC;
      ST_INIT:   cmd.op = OP_INIT;
      ST_COMMIT: cmd.op = OP_COMMIT;
      ST_ERES:   if (status.out_free) cmd.op = OP_EMIT_RES;
      ST_ELOSS: begin
        if (status.out_free) cmd.op = OP_EMIT_LOSS;
        cmd.last = (nslots == '0);
      end
      ST_EGRAD: begin
        if (status.out_free) cmd.op = OP_EMIT_GRAD;
        cmd.slot = cnt[SLOT_W-1:0];
        cmd.last = (cnt_inc == nslots);
      end
      ST_CLEAR:  cmd.op = OP_CLEAR;
      default: ;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      f      <= '0;
      cnt    <= '0;
      phi_ph <= 1'b0;
    end else begin
      state  <= state_next;
      f      <= f_next;
      cnt    <= cnt_next;
      phi_ph <= phi_ph_next;
    end
  end

endmodule

@@ hdl/acl_dp.sv @@
// ---------------------------------------------------------------------------
// Datapath
// Lag stores, one shared 32x32 multiplier, a saturating accumulator, the
// loss and gradient sums, and the output register.
// ---------------------------------------------------------------------------
module acl_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  acl_pkg::cfg_t        cfg,
  input  acl_pkg::dp_cmd_t     cmd,
  output acl_pkg::dp_status_t  status,
  input  logic [31:0]          in_sample,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [3:0]           out_slot,
  output logic [63:0]          out_value,
  output logic                 out_last
);
  import acl_pkg::*;

  logic signed [DATA_W-1:0] y_r;
  logic                     last_r;
  logic signed [DATA_W-1:0] e_r;
  logic signed [DATA_W-1:0] sample_lags [MAX_AR];
  logic signed [DATA_W-1:0] res_lags    [MAX_MA];
  logic signed [DATA_W-1:0] ar_sl       [MAX_AR][MAX_MA];
  logic signed [DATA_W-1:0] ma_sl       [MAX_MA][MAX_MA];
  logic signed [DATA_W-1:0] int_sl      [MAX_MA];
  logic signed [DATA_W-1:0] nv          [NUM_SLOTS];
  logic signed [ACC_W-1:0]  sums        [NUM_SLOTS];
  logic signed [ACC_W-1:0]  loss;
  logic [ORD_W-1:0]         warm;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod;

  logic [ORD_W-1:0]         ncond;
  logic [FILT_W-1:0]        ar_k;
  logic [FILT_W-1:0]        ma_k;
  logic [FILT_W-1:0]        nv_k;
  logic [AR_IW-1:0]         ai;
  logic [MA_IW-1:0]         mi;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  mul_p;
  logic signed [DATA_W:0]   init_d;
  logic signed [ACC_W-1:0]  rnd_b;
  logic signed [ACC_W-1:0]  rnd_r;
  logic signed [DATA_W-1:0] rnd;
  logic                     clear_now;

  // Index decode and status.
  always_comb begin
    ncond           = (cfg.p > cfg.q) ? cfg.p : cfg.q;
    ar_k            = FILT_W'(int'(cmd.filt) - AR_BASE);
    ma_k            = FILT_W'(int'(cmd.filt) - MA_BASE);
    nv_k            = FILT_W'(int'(cmd.filt) - 1);
    ai              = cmd.idx[AR_IW-1:0];
    mi              = cmd.idx[MA_IW-1:0];
    status.active   = (warm >= ncond);
    status.last_in  = last_r;
    status.out_free = !out_valid || out_ready;
    clear_now       = (cmd.op == OP_CLEAR);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL: begin
        if (cmd.use_phi) begin
          mul_a = DATA_W'(coef_at(cfg.ar_coeffs, cmd.idx));
          mul_b = sample_lags[ai];
        end else begin
          mul_a = DATA_W'(coef_at(cfg.ma_coeffs, cmd.idx));
          if (cmd.filt == '0) begin
            mul_b = res_lags[mi];
          end else if (int'(cmd.filt) < MA_BASE) begin
            mul_b = ar_sl[ar_k[AR_IW-1:0]][mi];
          end else if (int'(cmd.filt) < INT_FILT) begin
            mul_b = ma_sl[ma_k[MA_IW-1:0]][mi];
          end else begin
            mul_b = int_sl[mi];
          end
        end
      end
      OP_SQR: begin
        mul_a = e_r;
        mul_b = e_r;
      end
      OP_GMUL: begin
        mul_a = e_r;
        mul_b = nv[nv_k[SLOT_W-1:0]];
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Filter start value, before scaling to the accumulator's fraction.
  always_comb begin
    if (cmd.filt == '0) begin
      init_d = (DATA_W+1)'(y_r) - (DATA_W+1)'(cfg.intercept);
    end else if (int'(cmd.filt) < MA_BASE) begin
      init_d = -(DATA_W+1)'(sample_lags[ar_k[AR_IW-1:0]]);
    end else if (int'(cmd.filt) < INT_FILT) begin
      init_d = -(DATA_W+1)'(res_lags[ma_k[MA_IW-1:0]]);
    end else begin
      init_d = -(DATA_W+1)'(ONE_Q16);
    end
  end

  // Round half up back to Q16.16 and saturate to 32 bits.
  always_comb begin
    rnd_b = sat_add(acc, HALF_LSB);
    rnd_r = rnd_b >>> COEF_FRAC;
    if ((&rnd_r[ACC_W-1:DATA_W-1]) || !(|rnd_r[ACC_W-1:DATA_W-1])) begin
      rnd = rnd_r[DATA_W-1:0];
    end else begin
      rnd = rnd_r[ACC_W-1] ? DATA_MIN : DATA_MAX;
    end
  end

  // Series state and arithmetic.
  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      for (int j = 0; j < MAX_AR; j++) begin
        sample_lags[j] <= '0;
        for (int i = 0; i < MAX_MA; i++) ar_sl[j][i] <= '0;
      end
      for (int j = 0; j < MAX_MA; j++) begin
        res_lags[j] <= '0;
        int_sl[j]   <= '0;
        for (int i = 0; i < MAX_MA; i++) ma_sl[j][i] <= '0;
      end
      for (int j = 0; j < NUM_SLOTS; j++) sums[j] <= '0;
      loss <= '0;
      warm <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          y_r    <= signed'(in_sample);
          last_r <= in_last;
          e_r    <= '0;
          for (int j = 0; j < NUM_SLOTS; j++) nv[j] <= '0;
        end
        OP_WARM:  warm <= warm + ORD_W'(1);
        OP_INIT:  acc  <= ACC_W'(init_d) <<< COEF_FRAC;
        OP_MUL:   prod <= mul_p;
        OP_SQR:   prod <= mul_p;
        OP_GMUL:  prod <= mul_p;
        OP_MACC:  acc  <= sat_add(acc, -prod);
        OP_ROUND: begin
          if (cmd.filt == '0) begin
            e_r <= rnd;
          end else begin
            nv[nv_k[SLOT_W-1:0]] <= rnd;
          end
        end
        OP_LACC:  loss <= sat_add(loss, prod);
        OP_GACC:  sums[cmd.slot] <= sat_add(sums[cmd.slot], prod);
        OP_COMMIT: begin
          for (int j = MAX_AR - 1; j > 0; j--) sample_lags[j] <= sample_lags[j-1];
          sample_lags[0] <= y_r;
          for (int j = MAX_MA - 1; j > 0; j--) res_lags[j] <= res_lags[j-1];
          res_lags[0] <= e_r;
          if (cfg.grad_en) begin
            for (int k = 0; k < MAX_AR; k++) begin
              for (int j = MAX_MA - 1; j > 0; j--) ar_sl[k][j] <= ar_sl[k][j-1];
              ar_sl[k][0] <= nv[k];
            end
            for (int k = 0; k < MAX_MA; k++) begin
              for (int j = MAX_MA - 1; j > 0; j--) ma_sl[k][j] <= ma_sl[k][j-1];
              ma_sl[k][0] <= nv[MAX_AR+k];
            end
            for (int j = MAX_MA - 1; j > 0; j--) int_sl[j] <= int_sl[j-1];
            int_sl[0] <= nv[MAX_AR+MAX_MA];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register; a new result loads only when the old one is gone or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_EMIT_RES: begin
          out_valid <= 1'b1;
          out_kind  <= KIND_RES;
          out_slot  <= '0;
          out_value <= ACC_W'(e_r);
          out_last  <= !last_r;
        end
        OP_EMIT_LOSS: begin
          out_valid <= 1'b1;
          out_kind  <= KIND_LOSS;
          out_slot  <= '0;
          out_value <= loss;
          out_last  <= cmd.last;
        end
        OP_EMIT_GRAD: begin
          out_valid <= 1'b1;
          out_kind  <= KIND_GRAD;
          out_slot  <= OUT_SLOT_W'(cmd.slot);
          out_value <= sums[cmd.slot];
          out_last  <= cmd.last;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/arma_css_loss_gradient.sv @@
// ---------------------------------------------------------------------------
// ARMA conditional sum of squares loss and gradient engine
// Residual per sample; loss and gradient sums after the last sample.
// ---------------------------------------------------------------------------
//  Channel   Signals                       Payload
//  s_*       tvalid tready tdata tlast     sample (32), last_sample on tlast
//  m_*       tvalid tready tdata tuser     result_value (64); kind, slot in tuser;
//            tlast                         last_result on tlast
//  cfg_*     we index data                 register index (3), data (64)
//
//  One sample at a time through one 32x32 multiplier and one accumulator;
//  each multiply-accumulate is a multiply step, then an accumulate step.
//  Synchronous reset clears the configuration, lag lines, sums, loss and
//  warmup count. A stalled m_tready holds the sequencer at the next result.
// ---------------------------------------------------------------------------
module arma_css_loss_gradient (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] result_value
  output logic [5:0]  m_tuser,   // [1:0] kind, [5:2] slot
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import acl_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [1:0] out_kind;
  logic [3:0] out_slot;

  // Configuration registers.
  acl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  acl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // Datapath.
  acl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_sample (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_slot  (out_slot),
    .out_value (m_tdata),
    .out_last  (m_tlast)
  );

  // Result sideband packing.
  assign m_tuser = {out_slot, out_kind};

endmodule

@@ hdl/acl_checker.sv @@
// ---------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the engine over time.
// ---------------------------------------------------------------------------
`include "arma_css_loss_gradient_macros.svh"

module acl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [5:0]  m_tuser,
  input logic        m_tlast
);
  import acl_pkg::*;

  // The engine works on one sample at a time.
  `ACL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")

  // A stalled result holds.
  `ACL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // Only the three result kinds appear.
  `ACL_ASSERT_IMPL(a_kind_legal, m_tvalid, m_tuser[1:0] == KIND_RES || m_tuser[1:0] == KIND_LOSS || m_tuser[1:0] == KIND_GRAD, "illegal result kind")

  // Residual and loss results carry slot zero.
  `ACL_ASSERT_IMPL(a_slot_zero, m_tvalid && m_tuser[1:0] != KIND_GRAD, m_tuser[5:2] == '0, "slot set on non-gradient result")

endmodule

bind arma_css_loss_gradient acl_checker u_acl_checker (.*);

@@ bench/arma_css_loss_gradient_chk.sv @@
// ---------------------------------------------------------------------------
// Result checker for the ARMA loss and gradient engine
// Watches the configuration port and both item channels, predicts every
// residual, loss and gradient item in fixed point, and compares in order.
// ---------------------------------------------------------------------------
module arma_css_loss_gradient_chk
  import acl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // [63:0] result_value
  input  logic [5:0]  m_tuser,   // [1:0] kind, [5:2] slot
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef logic [3:0][31:0] lag_t;

  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic [63:0] value;
    logic        last;
  } result_t;

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  // Shadow copy of the registers.
  logic [2:0]  ar_ord, ma_ord;
  logic        int_on, grad_on;
  logic [31:0] icpt;
  logic [63:0] phi_reg, theta_reg;

  // Shadow copy of the series state.
  lag_t   y_hist, e_hist, dc_hist;
  lag_t   dphi_hist [4];
  lag_t   dtheta_hist [4];
  longint grad_acc [9];
  longint sq_acc;
  int     warm_cnt;

  result_t expected_q [$];

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  // Q16.16 value widened to 30 fraction bits, saturating.
  function automatic longint widen(longint v);
    longint lim;
    lim = S64_MAX >>> COEF_FRAC;
    if (v > lim) return S64_MAX;
    if (v < -lim - 1) return S64_MIN;
    return v <<< COEF_FRAC;
  endfunction

  // Round half up back to Q16.16 and clip to 32 bits.
  function automatic logic [31:0] to_q16(longint v);
    longint b, r;
    b = add_sat(v, longint'(1) <<< (COEF_FRAC - 1));
    r = b >>> COEF_FRAC;
    if (r > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (r < -64'sh8000_0000) return 32'h8000_0000;
    return r[31:0];
  endfunction

  function automatic longint coef(logic [63:0] r, int k);
    return longint'($signed(r[k*16 +: 16]));
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Subtract the MA part over a lag line and round.
  function automatic logic [31:0] ma_part(longint acc, int q, lag_t lags);
    for (int j = 0; j < q; j++) begin
      acc = add_sat(acc, -(coef(theta_reg, j) * sx(lags[j])));
    end
    return to_q16(acc);
  endfunction

  function automatic void clear_series();
    y_hist = '0;
    e_hist = '0;
    dc_hist = '0;
    for (int k = 0; k < 4; k++) begin
      dphi_hist[k] = '0;
      dtheta_hist[k] = '0;
    end
    for (int k = 0; k < 9; k++) grad_acc[k] = 0;
    sq_acc = 0;
    warm_cnt = 0;
  endfunction

  function automatic void add_result(kind_t kd, int sl, longint v, logic lst);
    result_t r;
    r.kind = kd;
    r.slot = 4'(sl);
    r.value = v;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  // Expected items of one accepted sample.
  function automatic void predict_sample(logic [31:0] y, logic lst);
    int p, q, slots;
    longint acc, pr;
    logic [31:0] e, dc;
    logic [31:0] dphi [4];
    logic [31:0] dtheta [4];
    p = (ar_ord > 4) ? 4 : int'(ar_ord);
    q = (ma_ord > 4) ? 4 : int'(ma_ord);
    e = '0;
    dc = '0;
    for (int k = 0; k < 4; k++) begin
      dphi[k] = '0;
      dtheta[k] = '0;
    end
    if (warm_cnt >= ((p > q) ? p : q)) begin
      acc = widen(sx(y) - sx(icpt));
      for (int j = 0; j < p; j++) begin
        acc = add_sat(acc, -(coef(phi_reg, j) * sx(y_hist[j])));
      end
      e = ma_part(acc, q, e_hist);
      sq_acc = add_sat(sq_acc, sx(e) * sx(e));
      if (grad_on) begin
        for (int k = 0; k < p; k++) begin
          dphi[k] = ma_part(widen(-sx(y_hist[k])), q, dphi_hist[k]);
          pr = sx(e) * sx(dphi[k]);
          grad_acc[k] = add_sat(add_sat(grad_acc[k], pr), pr);
        end
        for (int k = 0; k < q; k++) begin
          dtheta[k] = ma_part(widen(-sx(e_hist[k])), q, dtheta_hist[k]);
          pr = sx(e) * sx(dtheta[k]);
          grad_acc[p+k] = add_sat(add_sat(grad_acc[p+k], pr), pr);
        end
        dc = ma_part(widen(-65536), q, dc_hist);
        if (int_on) begin
          pr = sx(e) * sx(dc);
          grad_acc[p+q] = add_sat(add_sat(grad_acc[p+q], pr), pr);
        end
      end
    end else begin
      warm_cnt++;
    end
    if (grad_on) begin
      for (int k = 0; k < 4; k++) begin
        dphi_hist[k] = {dphi_hist[k][2:0], dphi[k]};
        dtheta_hist[k] = {dtheta_hist[k][2:0], dtheta[k]};
      end
      dc_hist = {dc_hist[2:0], dc};
    end
    y_hist = {y_hist[2:0], y};
    e_hist = {e_hist[2:0], e};

    add_result(KIND_RES, 0, sx(e), !lst);
    if (lst) begin
      slots = grad_on ? p + q + (int_on ? 1 : 0) : 0;
      add_result(KIND_LOSS, 0, sq_acc, slots == 0);
      for (int k = 0; k < slots; k++) begin
        add_result(KIND_GRAD, k, grad_acc[k], k + 1 == slots);
      end
      clear_series();
    end
  endfunction

  // Register writes, then input items, then output items, at each edge.
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      ar_ord = '0;
      ma_ord = '0;
      int_on = 1'b0;
      grad_on = 1'b1;
      icpt = '0;
      phi_reg = '0;
      theta_reg = '0;
      clear_series();
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_AR_ORDER:  ar_ord = cfg_data[2:0];
          REG_MA_ORDER:  ma_ord = cfg_data[2:0];
          REG_USE_INT:   int_on = cfg_data[0];
          REG_INTERCEPT: icpt = cfg_data[31:0];
          REG_AR_COEFFS: phi_reg = cfg_data;
          REG_MA_COEFFS: theta_reg = cfg_data;
          REG_GRAD_EN:   grad_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: %h", m_tdata);
          errors = errors + 1;
        end else begin
          r = expected_q.pop_front();
          if (m_tuser[1:0] != r.kind) begin
            $error("kind: expected %0d, got %0d", r.kind, m_tuser[1:0]);
            errors = errors + 1;
          end
          if (m_tuser[5:2] != r.slot) begin
            $error("slot: expected %0d, got %0d", r.slot, m_tuser[5:2]);
            errors = errors + 1;
          end
          if (m_tdata != r.value) begin
            $error("result_value: expected %h, got %h", r.value, m_tdata);
            errors = errors + 1;
          end
          if (m_tlast != r.last) begin
            $error("last_result: expected %0b, got %0b", r.last, m_tlast);
            errors = errors + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ bench/arma_css_loss_gradient_tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the ARMA loss and gradient engine
// Sends directed and random series under a range of model orders, coefficient
// sets and gradient modes, with random gaps and stalls on both channels; the
// checker module predicts and compares every result item.
// ---------------------------------------------------------------------------
module arma_css_loss_gradient_tb;
  import acl_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [31:0] sample
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // [63:0] result_value
  logic [5:0]  m_tuser;          // [1:0] kind, [5:2] slot
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_AR_ORDER;
  logic [63:0] cfg_data = '0;

  int errors, pending;
  int idle_cycles = 0;
  int hold_req = 0;
  bit calm = 1'b0;
  int sent = 0;

  always #4 clk = ~clk;

  arma_css_loss_gradient u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arma_css_loss_gradient_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // One sample item; called at a falling edge and returns at one.
  task automatic send_sample(logic [31:0] y, logic lst);
    int gap;
    s_tvalid = 1'b1;
    s_tdata = y;
    s_tlast = lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_model(int p, int q, bit ic, logic [31:0] c, logic [63:0] phis,
                           logic [63:0] thetas, bit ge);
    drain();
    write_reg(REG_AR_ORDER, 64'(p));
    write_reg(REG_MA_ORDER, 64'(q));
    write_reg(REG_USE_INT, 64'(ic));
    write_reg(REG_INTERCEPT, 64'(c));
    write_reg(REG_AR_COEFFS, phis);
    write_reg(REG_MA_COEFFS, thetas);
    write_reg(REG_GRAD_EN, 64'(ge));
  endtask

  // Mostly stable coefficients within plus or minus one half, some full range.
  function automatic logic [63:0] rand_coeffs();
    logic [63:0] r;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 5) == 0) r[k*16 +: 16] = 16'($urandom);
      else r[k*16 +: 16] = 16'($urandom_range(0, 16'h3FFF) - 16'h2000);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
    endcase
  endfunction

  task automatic send_series(int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: order zero, a lone last sample, then field extremes.
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);

    // Full orders with intercept; series shorter and longer than the warmup.
    set_model(4, 4, 1'b1, 32'h0001_8000, 64'h1000_F000_0800_2000,
              64'h0400_FC00_1000_E000, 1'b1);
    send_sample(32'h0003_0000, 1'b1);
    send_series(3);
    send_series(8);

    // Orders above the maximum clamp; gradients off; extreme coefficients.
    set_model(7, 7, 1'b1, 32'h8000_0000, 64'h8000_7FFF_8000_7FFF,
              64'h7FFF_8000_7FFF_8000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);

    // Gradients on; pure MA with the intercept slot left out, and pure AR with it.
    set_model(0, 2, 1'b0, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0000_0000_1800_E800, 1'b1);
    send_series(5);
    set_model(3, 0, 1'b1, 32'h0, 64'h0000_2000_C000_3FFF, 64'h0, 1'b1);
    send_series(5);

    // Receiver holds off while series keep coming, so the input backs up.
    hold_req = 300;
    send_series(6);

    // Random models and series; some phases run with no idling.
    while (sent < 90) begin
      set_model($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1),
                $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 32'h3_FFFF))
                  - 32'h2_0000,
                rand_coeffs(), rand_coeffs(), $urandom_range(0, 3) != 0);
      calm = ($urandom_range(0, 4) == 0);
      for (int s = 0; s < 3; s++) send_series($urandom_range(1, 9));
      calm = 1'b0;
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
